@@ rtl/vfv_pkg.sv @@
// Shared types, constants and the sequencer control store of the voxel face visibility block.
package vfv_pkg;

   localparam int MAX_DIM_DEFAULT = 16;

   localparam int POS_W     = 4;
   localparam int SIZE_W    = 5;
   localparam int MASK_W    = 6;
   localparam int COUNT_W   = 3;
   localparam int CSR_IDX_W = 2;
   localparam int UPC_W     = 4;

   localparam logic [SIZE_W-1:0] SIZE_RESET = SIZE_W'(16);

   localparam logic [CSR_IDX_W-1:0] CSR_SIZE_X = 2'd0;
   localparam logic [CSR_IDX_W-1:0] CSR_SIZE_Y = 2'd1;
   localparam logic [CSR_IDX_W-1:0] CSR_SIZE_Z = 2'd2;

   localparam logic FUNC_WRITE = 1'b0;
   localparam logic FUNC_QUERY = 1'b1;

   typedef logic [UPC_W-1:0] upc_type;

   // Step addresses of the control store
   localparam upc_type UPC_CLR  = 4'd0;
   localparam upc_type UPC_IDLE = 4'd1;
   localparam upc_type UPC_Q1   = 4'd2;
   localparam upc_type UPC_Q2   = 4'd3;
   localparam upc_type UPC_Q3   = 4'd4;
   localparam upc_type UPC_Q4   = 4'd5;
   localparam upc_type UPC_Q5   = 4'd6;
   localparam upc_type UPC_Q6   = 4'd7;
   localparam upc_type UPC_LAST = 4'd8;

   typedef enum logic [1:0] {
      SEQ_CLEAR,
      SEQ_WAIT,
      SEQ_NEXT,
      SEQ_FINISH
   } seq_type;

   // Neighbour directions; face mask bit i belongs to direction i+1
   typedef enum logic [2:0] {
      DIR_CENTRE,
      DIR_FRONT,
      DIR_RIGHT,
      DIR_TOP,
      DIR_LEFT,
      DIR_BOTTOM,
      DIR_BACK
   } dir_type;

   typedef struct packed {
      seq_type seq;
      logic    rd;
      dir_type rd_dir;
      logic    cap;
      dir_type cap_dir;
   } ucode_type;

   function automatic ucode_type ucode_rom(input upc_type upc);
      ucode_type w;
      w = '{seq: SEQ_WAIT, rd: 1'b0, rd_dir: DIR_CENTRE, cap: 1'b0, cap_dir: DIR_CENTRE};
      case (upc)
         UPC_CLR:  w.seq = SEQ_CLEAR;
         UPC_IDLE: w.seq = SEQ_WAIT;
         UPC_Q1:   w = '{SEQ_NEXT, 1'b1, DIR_FRONT,  1'b1, DIR_CENTRE};
         UPC_Q2:   w = '{SEQ_NEXT, 1'b1, DIR_RIGHT,  1'b1, DIR_FRONT};
         UPC_Q3:   w = '{SEQ_NEXT, 1'b1, DIR_TOP,    1'b1, DIR_RIGHT};
         UPC_Q4:   w = '{SEQ_NEXT, 1'b1, DIR_LEFT,   1'b1, DIR_TOP};
         UPC_Q5:   w = '{SEQ_NEXT, 1'b1, DIR_BOTTOM, 1'b1, DIR_LEFT};
         UPC_Q6:   w = '{SEQ_NEXT, 1'b1, DIR_BACK,   1'b1, DIR_BOTTOM};
         UPC_LAST: w.seq = SEQ_FINISH;
         default:  w.seq = SEQ_WAIT;
      endcase
      return w;
   endfunction

endpackage

@@ rtl/vfv_channels.sv @@
// Valid/ready channel interfaces for request and response items.
interface vfv_req_if
   import vfv_pkg::*;
();
   logic             valid;
   logic             ready;
   logic             func;
   logic [POS_W-1:0] pos_x;
   logic [POS_W-1:0] pos_y;
   logic [POS_W-1:0] pos_z;
   logic             solid_in;

   modport source (output valid, func, pos_x, pos_y, pos_z, solid_in, input ready);
   modport sink   (input valid, func, pos_x, pos_y, pos_z, solid_in, output ready);
endinterface

interface vfv_rsp_if
   import vfv_pkg::*;
();
   logic               valid;
   logic               ready;
   logic [POS_W-1:0]   out_x;
   logic [POS_W-1:0]   out_y;
   logic [POS_W-1:0]   out_z;
   logic               is_solid;
   logic [MASK_W-1:0]  face_mask;
   logic [COUNT_W-1:0] face_count;
   logic               in_range;

   modport source (output valid, out_x, out_y, out_z, is_solid, face_mask, face_count,
                   in_range, input ready);
   modport sink   (input valid, out_x, out_y, out_z, is_solid, face_mask, face_count,
                   in_range, output ready);
endinterface

@@ rtl/vfv_ram.sv @@
// Generic single-port RAM with registered read.
module vfv_ram #(
   parameter int WIDTH = 1,
   parameter int DEPTH = 4096
) (
   input  logic                     clock,
   input  logic                     we,
   input  logic                     re,
   input  logic [$clog2(DEPTH)-1:0] addr,
   input  logic [WIDTH-1:0]         wdata,
   output logic [WIDTH-1:0]         rdata
);

   logic [WIDTH-1:0] mem [DEPTH];
   logic [WIDTH-1:0] rdata_ff;

   always_ff @(posedge clock) begin
      if (we) begin
         mem[addr] <= wdata;
      end
      if (re) begin
         rdata_ff <= mem[addr];
      end
   end

   assign rdata = rdata_ff;

endmodule

@@ rtl/voxel_face_visibility_top.sv @@
// Top level of the voxel face visibility block: sequencer, occupancy store and result register.
//
// Keeps a MAX_DIM^3 one-bit occupancy grid and answers face visibility
// queries. A write item (func 0) sets or clears one voxel; it yields no
// response. A query item (func 1) yields one response item: the occupancy
// store has one port, and the microcoded sequencer reads the voxel on the
// accept cycle, then its six neighbours in the following six steps, and
// builds the result in the last step, where the next item can already be
// taken. While a query runs, the next item is taken no earlier than its
// last step. One response item can wait in the output register while the
// next query runs; the sequencer only holds in its last step if that
// register is still full. After reset the store, which holds
// 2^(3*ceil(log2 MAX_DIM)) voxels (4096 at the default MAX_DIM of 16), is
// swept to empty, one voxel a cycle; req_chan.ready stays low meanwhile. The
// size registers (index 0 x, 1 y, 2 z, reset 16) can be written at any time
// but should only change while the block is idle; sizes above MAX_DIM act as
// MAX_DIM, and neighbours beyond the size count as empty.
module voxel_face_visibility_top
   import vfv_pkg::*;
#(
   parameter int MAX_DIM = MAX_DIM_DEFAULT
) (
   input  logic                 clock,
   input  logic                 reset,
   vfv_req_if.sink              req_chan,
   vfv_rsp_if.source            rsp_chan,
   input  logic                 csr_wr_en,
   input  logic [CSR_IDX_W-1:0] csr_index,
   input  logic [SIZE_W-1:0]    csr_wr_data
);

   // Coordinate bits per axis inside the store, and a width that holds both
   // the store coordinate and the five-bit neighbour coordinate.
   localparam int CW    = $clog2(MAX_DIM);
   localparam int AW    = 3 * CW;
   localparam int DEPTH = 2 ** AW;
   localparam int XW    = (CW > SIZE_W) ? CW : SIZE_W;

   // Configuration
   logic [SIZE_W-1:0] size_x_ff, size_y_ff, size_z_ff;
   logic [SIZE_W-1:0] eff_x, eff_y, eff_z;

   // Sequencer
   upc_type   upc_ff, upc_in;
   ucode_type uc;
   logic [AW-1:0] clr_cnt_ff, clr_cnt_in;

   // Item under work
   logic [POS_W-1:0] item_x_ff, item_y_ff, item_z_ff;
   logic [POS_W-1:0] item_x_in, item_y_in, item_z_in;
   logic             inside_ff, inside_in;
   logic [6:0]       occ_ff, occ_in;
   logic             rd_ok_ff, rd_ok_in;

   // Result register
   logic               rsp_valid_ff, rsp_valid_in;
   logic [POS_W-1:0]   out_x_ff, out_y_ff, out_z_ff, out_x_in, out_y_in, out_z_in;
   logic               is_solid_ff, is_solid_in;
   logic [MASK_W-1:0]  face_mask_ff, face_mask_in;
   logic [COUNT_W-1:0] face_count_ff, face_count_in;
   logic               in_range_ff, in_range_in;

   // Datapath
   logic          use_req;
   dir_type       dir;
   logic [SIZE_W-1:0] bx, by, bz, cx, cy, cz;
   logic [XW-1:0]     cx_w, cy_w, cz_w;
   logic          coord_ok;
   logic          out_free, accept, acc_query, acc_write;
   logic          mem_we, mem_re, mem_wdata, mem_rdata;
   logic [AW-1:0] mem_addr;
   logic          here, back_occ;
   logic [MASK_W-1:0] empty_nb;

   assign uc = ucode_rom(upc_ff);

   // Sizes beyond the grid saturate at MAX_DIM
   assign eff_x = (32'(size_x_ff) > MAX_DIM) ? SIZE_W'(MAX_DIM) : size_x_ff;
   assign eff_y = (32'(size_y_ff) > MAX_DIM) ? SIZE_W'(MAX_DIM) : size_y_ff;
   assign eff_z = (32'(size_z_ff) > MAX_DIM) ? SIZE_W'(MAX_DIM) : size_z_ff;

   // Handshake: items are taken while waiting, and in the last query step
   // once the result has somewhere to go.
   assign out_free       = !rsp_valid_ff || rsp_chan.ready;
   assign req_chan.ready = (uc.seq == SEQ_WAIT) || ((uc.seq == SEQ_FINISH) && out_free);
   assign accept         = req_chan.valid && req_chan.ready;
   assign acc_query      = accept && (req_chan.func == FUNC_QUERY);
   assign acc_write      = accept && (req_chan.func == FUNC_WRITE);

   // Address generation: request coordinates on the accept step, otherwise
   // the stored item moved one voxel in the step's direction.
   assign use_req = (uc.seq == SEQ_WAIT) || (uc.seq == SEQ_FINISH);
   assign dir     = use_req ? DIR_CENTRE : uc.rd_dir;
   assign bx      = SIZE_W'(use_req ? req_chan.pos_x : item_x_ff);
   assign by      = SIZE_W'(use_req ? req_chan.pos_y : item_y_ff);
   assign bz      = SIZE_W'(use_req ? req_chan.pos_z : item_z_ff);

   always_comb begin
      cx = bx;
      cy = by;
      cz = bz;
      case (dir)
         DIR_CENTRE: ;
         DIR_FRONT:  cz = bz + SIZE_W'(1);
         DIR_RIGHT:  cx = bx + SIZE_W'(1);
         DIR_TOP:    cy = by + SIZE_W'(1);
         DIR_LEFT:   cx = bx - SIZE_W'(1);   // wraps to 31, always outside
         DIR_BOTTOM: cy = by - SIZE_W'(1);
         DIR_BACK:   cz = bz - SIZE_W'(1);
         default: ;
      endcase
   end

   assign coord_ok = (cx < eff_x) && (cy < eff_y) && (cz < eff_z);
   assign cx_w     = XW'(cx);
   assign cy_w     = XW'(cy);
   assign cz_w     = XW'(cz);

   // Occupancy store port
   assign mem_we    = (uc.seq == SEQ_CLEAR) || (acc_write && coord_ok);
   assign mem_re    = acc_query || uc.rd;
   assign mem_wdata = (uc.seq == SEQ_CLEAR) ? 1'b0 : req_chan.solid_in;
   assign mem_addr  = (uc.seq == SEQ_CLEAR) ? clr_cnt_ff
                    : {cz_w[CW-1:0], cy_w[CW-1:0], cx_w[CW-1:0]};

   vfv_ram #(
      .WIDTH (1),
      .DEPTH (DEPTH)
   ) u_occ_ram (
      .clock (clock),
      .we    (mem_we),
      .re    (mem_re),
      .addr  (mem_addr),
      .wdata (mem_wdata),
      .rdata (mem_rdata)
   );

   // Result assembly from captured neighbours plus the back read in flight
   assign here     = occ_ff[DIR_CENTRE];
   assign back_occ = mem_rdata && rd_ok_ff;
   assign empty_nb = ~{back_occ, occ_ff[DIR_BOTTOM], occ_ff[DIR_LEFT], occ_ff[DIR_TOP],
                       occ_ff[DIR_RIGHT], occ_ff[DIR_FRONT]};

   always_comb begin
      upc_in        = upc_ff;
      clr_cnt_in    = clr_cnt_ff;
      item_x_in     = item_x_ff;
      item_y_in     = item_y_ff;
      item_z_in     = item_z_ff;
      inside_in     = inside_ff;
      occ_in        = occ_ff;
      rd_ok_in      = mem_re ? coord_ok : rd_ok_ff;
      rsp_valid_in  = rsp_valid_ff && !rsp_chan.ready;
      out_x_in      = out_x_ff;
      out_y_in      = out_y_ff;
      out_z_in      = out_z_ff;
      is_solid_in   = is_solid_ff;
      face_mask_in  = face_mask_ff;
      face_count_in = face_count_ff;
      in_range_in   = in_range_ff;

      if (uc.cap) begin
         occ_in[uc.cap_dir] = mem_rdata && rd_ok_ff;
      end

      if (acc_query) begin
         item_x_in = req_chan.pos_x;
         item_y_in = req_chan.pos_y;
         item_z_in = req_chan.pos_z;
         inside_in = coord_ok;
      end

      case (uc.seq)
         SEQ_CLEAR: begin
            clr_cnt_in = clr_cnt_ff + AW'(1);
            if (&clr_cnt_ff) begin
               upc_in = UPC_IDLE;
            end
         end
         SEQ_WAIT: begin
            if (acc_query) begin
               upc_in = UPC_Q1;
            end
         end
         SEQ_NEXT: begin
            upc_in = upc_ff + UPC_W'(1);
         end
         SEQ_FINISH: begin
            if (out_free) begin
               rsp_valid_in  = 1'b1;
               out_x_in      = item_x_ff;
               out_y_in      = item_y_ff;
               out_z_in      = item_z_ff;
               is_solid_in   = here;
               face_mask_in  = here ? empty_nb : '0;
               face_count_in = here ? COUNT_W'($countones(empty_nb)) : '0;
               in_range_in   = inside_ff;
               upc_in        = acc_query ? UPC_Q1 : UPC_IDLE;
            end
         end
         default: upc_in = UPC_IDLE;
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         upc_ff       <= UPC_CLR;
         clr_cnt_ff   <= '0;
         rsp_valid_ff <= 1'b0;
         size_x_ff    <= SIZE_RESET;
         size_y_ff    <= SIZE_RESET;
         size_z_ff    <= SIZE_RESET;
      end else begin
         upc_ff       <= upc_in;
         clr_cnt_ff   <= clr_cnt_in;
         rsp_valid_ff <= rsp_valid_in;
         if (csr_wr_en) begin
            case (csr_index)
               CSR_SIZE_X: size_x_ff <= csr_wr_data;
               CSR_SIZE_Y: size_y_ff <= csr_wr_data;
               CSR_SIZE_Z: size_z_ff <= csr_wr_data;
               default: ;
            endcase
         end
      end
      item_x_ff     <= item_x_in;
      item_y_ff     <= item_y_in;
      item_z_ff     <= item_z_in;
      inside_ff     <= inside_in;
      occ_ff        <= occ_in;
      rd_ok_ff      <= rd_ok_in;
      out_x_ff      <= out_x_in;
      out_y_ff      <= out_y_in;
      out_z_ff      <= out_z_in;
      is_solid_ff   <= is_solid_in;
      face_mask_ff  <= face_mask_in;
      face_count_ff <= face_count_in;
      in_range_ff   <= in_range_in;
   end

   assign rsp_chan.valid      = rsp_valid_ff;
   assign rsp_chan.out_x      = out_x_ff;
   assign rsp_chan.out_y      = out_y_ff;
   assign rsp_chan.out_z      = out_z_ff;
   assign rsp_chan.is_solid   = is_solid_ff;
   assign rsp_chan.face_mask  = face_mask_ff;
   assign rsp_chan.face_count = face_count_ff;
   assign rsp_chan.in_range   = in_range_ff;

endmodule

@@ rtl/vfv_checker.sv @@
// Port-level checks for the voxel face visibility block, bound to the top level.
module vfv_checker
   import vfv_pkg::*;
(
   input logic               clock,
   input logic               reset,
   input logic               req_ready,
   input logic               rsp_valid,
   input logic               rsp_ready,
   input logic [POS_W-1:0]   out_x,
   input logic [POS_W-1:0]   out_y,
   input logic [POS_W-1:0]   out_z,
   input logic               is_solid,
   input logic [MASK_W-1:0]  face_mask,
   input logic [COUNT_W-1:0] face_count,
   input logic               in_range
);

   // A held response item keeps its payload
   a_rsp_hold: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && !rsp_ready |=> rsp_valid && $stable({out_x, out_y, out_z, is_solid,
                                                        face_mask, face_count, in_range}))
      else $error("response item changed while stalled");

   a_count: assert property (@(posedge clock) disable iff (reset)
      rsp_valid |-> 32'(face_count) == $countones(face_mask))
      else $error("face count does not match mask");

   // Out-of-range or empty voxels show no faces
   a_no_faces: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && (!in_range || !is_solid) |-> face_mask == '0 && (is_solid == 1'b0 || in_range))
      else $error("faces reported for empty or out-of-range voxel");

   // Store sweep runs after reset before any item is taken
   a_clear_first: assert property (@(posedge clock) disable iff (reset)
      $fell(reset) |-> !req_ready && !rsp_valid)
      else $error("block ready before occupancy clear");

endmodule

bind voxel_face_visibility_top vfv_checker u_vfv_checker (
   .clock      (clock),
   .reset      (reset),
   .req_ready  (req_chan.ready),
   .rsp_valid  (rsp_chan.valid),
   .rsp_ready  (rsp_chan.ready),
   .out_x      (rsp_chan.out_x),
   .out_y      (rsp_chan.out_y),
   .out_z      (rsp_chan.out_z),
   .is_solid   (rsp_chan.is_solid),
   .face_mask  (rsp_chan.face_mask),
   .face_count (rsp_chan.face_count),
   .in_range   (rsp_chan.in_range)
);
